/* hw/rtl/tte_pkg.sv */
// Shared types and codes for the timer table expiry block.
package tte_pkg;

  localparam int unsigned OwnerW   = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned TimeoutW = 31;
  localparam int unsigned CountW   = 5;
  localparam int unsigned OpW      = 2;
  localparam int unsigned KindW    = 2;

  // At most this many expired timers are reported by one tick.
  localparam int unsigned MaxOut   = 16;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_ADD_OK     = 2'd0,
    KIND_ADD_FULL   = 2'd1,
    KIND_CANCEL     = 2'd2,
    KIND_EXPIRED    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [OwnerW-1:0] owner;
    logic [IdW-1:0]    id;
    logic [TimeW-1:0]  deadline;
  } entry_t;

endpackage

/* hw/rtl/timer_table_expiry.sv */
// Ordered timer table with add, cancel and millisecond tick expiry.
// Add: the result goes through the pending and then the output register; the next item
// is taken only after that. Cancel and tick: one pass over the table, one entry per
// cycle through the single read and the single write port, unless a stalled output blocks
// a tick, and holds an item whenever its result waits for the output register. Reset
// empties the table and clears the millisecond count; the table needs no clearing pass.
module timer_table_expiry
  import tte_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      operation_i,
  input  logic [OwnerW-1:0]   owner_i,
  input  logic [IdW-1:0]      timer_id_i,
  input  logic [TimeoutW-1:0] timeout_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KindW-1:0]    kind_o,
  output logic [OwnerW-1:0]   fired_owner_o,
  output logic [IdW-1:0]      fired_id_o,
  output logic [CountW-1:0]   removed_count_o,
  output logic                last_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FireW = $clog2(MaxOut + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
  localparam logic [FireW-1:0] MaxOutC = FireW'(MaxOut);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [CntW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   w_ptr_q, w_ptr_d;
  logic [FireW-1:0]  fired_q, fired_d;
  logic              is_tick_q, is_tick_d;
  logic              pend_valid_q, pend_valid_d;
  logic              out_valid_q, out_valid_d;

  kind_e             pend_kind_q, pend_kind_d;
  logic [OwnerW-1:0] pend_owner_q, pend_owner_d;
  logic [IdW-1:0]    pend_id_q, pend_id_d;
  logic [CountW-1:0] pend_cnt_q, pend_cnt_d;

  kind_e             out_kind_q, out_kind_d;
  logic [OwnerW-1:0] out_owner_q, out_owner_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;
  logic              out_last_q, out_last_d;

  entry_t            mem_q [TABLE_DEPTH];
  entry_t            mem_rdata_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;

  logic              in_acc;
  logic              out_free;
  logic              hit;
  logic              blocked;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A tick hits an expired entry while under the fire limit; a cancel hits a match.
  always_comb begin
    if (is_tick_q) begin
      hit = (mem_rdata_q.deadline <= time_q) && (fired_q < MaxOutC);
    end else begin
      hit = (mem_rdata_q.owner == pend_owner_q) && (mem_rdata_q.id == pend_id_q);
    end
  end

  // A second expired entry can only be taken once the held one has gone out.
  assign blocked = is_tick_q && hit && pend_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    time_d       = time_q;
    rd_ptr_d     = rd_ptr_q;
    w_ptr_d      = w_ptr_q;
    fired_d      = fired_q;
    is_tick_d    = is_tick_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_owner_d = pend_owner_q;
    pend_id_d    = pend_id_q;
    pend_cnt_d   = pend_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_kind_d   = out_kind_q;
    out_owner_d  = out_owner_q;
    out_id_d     = out_id_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = mem_rdata_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          pend_owner_d = owner_i;
          pend_id_d    = timer_id_i;
          pend_cnt_d   = '0;
          w_ptr_d      = '0;
          rd_ptr_d     = CntW'(1);
          fired_d      = '0;
          case (operation_i)
            OP_ADD: begin
              pend_valid_d = 1'b1;
              state_d      = StFinish;
              if (used_q == DepthC) begin
                pend_kind_d = KIND_ADD_FULL;
              end else begin
                pend_kind_d        = KIND_ADD_OK;
                mem_we             = 1'b1;
                mem_waddr          = used_q[IdxW-1:0];
                mem_wdata.owner    = owner_i;
                mem_wdata.id       = timer_id_i;
                mem_wdata.deadline = time_q + TimeW'(timeout_ms_i);
                used_d             = used_q + CntW'(1);
              end
            end
            OP_CANCEL, OP_TICK: begin
              is_tick_d = (operation_i == OP_TICK);
              if (operation_i == OP_TICK) begin
                time_d       = time_q + TimeW'(1);
                pend_valid_d = 1'b0;
              end else begin
                pend_valid_d = 1'b1;
                pend_kind_d  = KIND_CANCEL;
              end
              if (used_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = StScan;
              end else begin
                state_d   = StFinish;
              end
            end
            default: begin
            end
          endcase
        end
      end

      StScan: begin
        if (!blocked) begin
          if (!hit) begin
            // Surviving entries slide down to keep insertion order.
            mem_we    = 1'b1;
            mem_waddr = w_ptr_q[IdxW-1:0];
            mem_wdata = mem_rdata_q;
            w_ptr_d   = w_ptr_q + CntW'(1);
          end else if (is_tick_q) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = pend_kind_q;
              out_owner_d = pend_owner_q;
              out_id_d    = pend_id_q;
              out_cnt_d   = pend_cnt_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_kind_d  = KIND_EXPIRED;
            pend_owner_d = mem_rdata_q.owner;
            pend_id_d    = mem_rdata_q.id;
            pend_cnt_d   = '0;
            fired_d      = fired_q + FireW'(1);
          end else if (pend_cnt_q != CountMax) begin
            pend_cnt_d = pend_cnt_q + CountW'(1);
          end

          if (rd_ptr_q == used_q) begin
            used_d  = hit ? w_ptr_q : (w_ptr_q + CntW'(1));
            state_d = StFinish;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rd_ptr_q[IdxW-1:0];
            rd_ptr_d  = rd_ptr_q + CntW'(1);
          end
        end
      end

      StFinish: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = pend_kind_q;
          out_owner_d  = pend_owner_q;
          out_id_d     = pend_id_q;
          out_cnt_d    = pend_cnt_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      used_q       <= '0;
      time_q       <= '0;
      rd_ptr_q     <= '0;
      w_ptr_q      <= '0;
      fired_q      <= '0;
      is_tick_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      time_q       <= time_d;
      rd_ptr_q     <= rd_ptr_d;
      w_ptr_q      <= w_ptr_d;
      fired_q      <= fired_d;
      is_tick_q    <= is_tick_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q  <= pend_kind_d;
    pend_owner_q <= pend_owner_d;
    pend_id_q    <= pend_id_d;
    pend_cnt_q   <= pend_cnt_d;
    out_kind_q   <= out_kind_d;
    out_owner_q  <= out_owner_d;
    out_id_q     <= out_id_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign fired_owner_o   = out_owner_q;
  assign fired_id_o      = out_id_q;
  assign removed_count_o = out_cnt_q;
  assign last_o          = out_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= DepthC)
    else $error("timer table fill count above depth");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !pend_valid_q)
    else $error("result left pending after an item finished");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == OP_ADD && used_q == DepthC |=>
      pend_kind_q == KIND_ADD_FULL && used_q == DepthC)
    else $error("add to a full table was not rejected");

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fired_q <= MaxOutC)
    else $error("too many expired timers reported by one tick");

endmodule
